[rtl/nfb_pkg.sv]
// shared types, constants and register codes of the notch filter bank
package nfb_pkg;

	localparam int NOTCH_COUNT_DEF = 16;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int COEF_BITS_DEF   = 24;

	localparam int SLOT_W   = 4;
	localparam int FREQ_W   = 20;
	localparam int HOLD_W   = 16;
	localparam int GAIN_W   = 17;
	localparam int DLY_W    = 40;
	localparam int COUNT_W  = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_DELTA   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_DELTA   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NYQUIST_LIMIT = 3'd4;

	localparam logic [HOLD_W-1:0] HOLD_LENGTH_RST   = 16'd8820;
	localparam logic [15:0]       RELEASE_STEP_RST  = 16'd15;
	localparam logic [FREQ_W-1:0] SMALL_DELTA_RST   = 20'd43;
	localparam logic [FREQ_W-1:0] LARGE_DELTA_RST   = 20'd345;
	localparam logic [FREQ_W-1:0] NYQUIST_LIMIT_RST = 20'd352800;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

	typedef struct packed {
		logic [HOLD_W-1:0] hold_length;
		logic [15:0]       release_step;
		logic [FREQ_W-1:0] small_delta;
		logic [FREQ_W-1:0] large_delta;
		logic [FREQ_W-1:0] nyquist_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic rd_slot;
		logic env;
		logic y_en;
		logic fb_en;
		logic gm_en;
		logic wb_en;
		logic tone_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_tone;
		logic in_ok;
		logic skip;
	} status_t;

endpackage

[rtl/nfb_ram.sv]
// generic single write, single read ram with registered read data
module nfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/nfb_ctrl.sv]
// sequencer of the notch filter bank: item handshake and per-notch steps
module nfb_ctrl #(
	parameter int NOTCH_COUNT = nfb_pkg::NOTCH_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  nfb_pkg::status_t     st,
	output nfb_pkg::cmd_t        cmd,
	output logic [((NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1)-1:0] idx,
	output logic [((NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1)-1:0] rd_idx
);
	localparam int AW = (NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TWR  = 4'd1;
	localparam logic [3:0] S_ENV  = 4'd2;
	localparam logic [3:0] S_Y    = 4'd3;
	localparam logic [3:0] S_FB   = 4'd4;
	localparam logic [3:0] S_GM   = 4'd5;
	localparam logic [3:0] S_WB   = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;

	logic [3:0]    state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic          ovalid_q;
	logic          last;

	assign last     = idx_q == AW'(NOTCH_COUNT - 1);
	assign idx      = idx_q;
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = ovalid_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		rd_idx  = idx_q + AW'(1);
		case (state_q)
			S_IDLE: begin
				rd_idx = '0;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (st.in_tone) begin
						if (st.in_ok) begin
							cmd.rd_en   = 1'b1;
							cmd.rd_slot = 1'b1;
							state_d     = S_TWR;
						end else begin
							state_d = S_DONE;
						end
					end else begin
						cmd.rd_en = 1'b1;
						idx_d     = '0;
						state_d   = S_ENV;
					end
				end
			end
			S_TWR: begin
				cmd.tone_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_ENV: begin
				cmd.env = 1'b1;
				if (st.skip) begin
					if (last) begin
						state_d = S_DONE;
					end else begin
						cmd.rd_en = 1'b1;
						idx_d     = idx_q + AW'(1);
					end
				end else begin
					state_d = S_Y;
				end
			end
			S_Y: begin
				cmd.y_en = 1'b1;
				state_d  = S_FB;
			end
			S_FB: begin
				cmd.fb_en = 1'b1;
				state_d   = S_GM;
			end
			S_GM: begin
				cmd.gm_en = 1'b1;
				state_d   = S_WB;
			end
			S_WB: begin
				cmd.wb_en = 1'b1;
				if (last) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					idx_d     = idx_q + AW'(1);
					state_d   = S_ENV;
				end
			end
			S_DONE: begin
				if (!ovalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/nfb_dp.sv]
// datapath of the notch filter bank: slot store, envelope and biquad arithmetic
module nfb_dp #(
	parameter int NOTCH_COUNT = nfb_pkg::NOTCH_COUNT_DEF,
	parameter int SAMPLE_BITS = nfb_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = nfb_pkg::COEF_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nfb_pkg::cfg_t                      cfg,
	input  logic                               in_op,
	input  logic signed [SAMPLE_BITS-1:0]      in_sample,
	input  logic [nfb_pkg::SLOT_W-1:0]         in_slot,
	input  logic [nfb_pkg::FREQ_W-1:0]         in_freq,
	input  logic signed [COEF_BITS-1:0]        in_b0,
	input  logic signed [COEF_BITS-1:0]        in_b1,
	input  logic signed [COEF_BITS-1:0]        in_a2,
	input  nfb_pkg::cmd_t                      cmd,
	input  logic [((NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1)-1:0] idx,
	input  logic [((NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1)-1:0] rd_idx,
	output nfb_pkg::status_t                   st,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic [nfb_pkg::COUNT_W-1:0]        out_count
);
	localparam int AW  = (NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1;
	localparam int S   = SAMPLE_BITS;
	localparam int C   = COEF_BITS;
	localparam int DW  = nfb_pkg::DLY_W;
	localparam int FW  = nfb_pkg::FREQ_W;
	localparam int HW  = nfb_pkg::HOLD_W;
	localparam int GW  = nfb_pkg::GAIN_W;
	localparam int OD1 = 3 * C;
	localparam int OD2 = OD1 + DW;
	localparam int OFQ = OD2 + DW;
	localparam int OHL = OFQ + FW;
	localparam int OGN = OHL + HW;
	localparam int EW  = OGN + GW;
	localparam int WW  = 48;
	localparam int PSH   = S + C - 34;
	localparam int PSH_P = (PSH > 0) ? PSH : 0;
	localparam int PSH_N = (PSH < 0) ? -PSH : 0;

	localparam logic [EW-1:0] RST_ENT = {{(EW-1){1'b0}}, 1'b1} << (C - 2);
	localparam logic signed [WW-1:0] YMAX = {{(WW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [WW-1:0] YMIN = ~YMAX;
	localparam logic signed [WW-1:0] ZMAX = {{(WW-39){1'b0}}, {39{1'b1}}};
	localparam logic signed [WW-1:0] ZMIN = ~ZMAX;
	localparam logic signed [S+3:0]  XMAX = {5'b0, {(S-1){1'b1}}};
	localparam logic signed [S+3:0]  XMIN = ~XMAX;

	// latched item
	logic                 op_q;
	logic [nfb_pkg::SLOT_W-1:0] slot_q;
	logic [FW-1:0]        freq_q;
	logic signed [C-1:0]  b0_q, b1_q, a2_q;
	logic signed [S-1:0]  x_q;

	logic [NOTCH_COUNT-1:0] act_q;
	logic [NOTCH_COUNT-1:0] vld_q;
	logic                   vld_rd_q;
	logic [nfb_pkg::COUNT_W-1:0] cnt_q;

	logic [EW-1:0] rd_data, ent, wr_data;
	logic [AW-1:0] raddr, waddr, slot_a;
	logic          we;

	logic signed [C-1:0]  e_b0, e_b1, e_a2;
	logic signed [DW-1:0] e_d1, e_d2;
	logic [FW-1:0]        e_fq;
	logic [HW-1:0]        e_hl;
	logic [GW-1:0]        e_gn;

	// arithmetic registers
	logic signed [S+C-1:0]  pb0_q, pb1_q;
	logic signed [31:0]     y_q;
	logic signed [C+31:0]   fa1_q, fa2_q;
	logic signed [S:0]      diff_q;
	logic signed [S+18:0]   gm_q;
	logic signed [DW-1:0]   d1n_q, d2n_q;
	logic [GW-1:0]          gn_q;
	logic [HW-1:0]          hn_q;

	assign slot_a = AW'(slot_q);
	assign raddr  = cmd.rd_slot ? AW'(in_slot) : rd_idx;
	assign waddr  = cmd.tone_wr ? slot_a : idx;

	assign st.in_tone = in_op;
	assign st.in_ok   = 32'(in_slot) < NOTCH_COUNT;

	nfb_ram #(.WIDTH(EW), .DEPTH(NOTCH_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// an entry never written reads as its reset value
	assign ent  = vld_rd_q ? rd_data : RST_ENT;
	assign e_b0 = ent[C-1:0];
	assign e_b1 = ent[2*C-1:C];
	assign e_a2 = ent[3*C-1:2*C];
	assign e_d1 = ent[OD1 +: DW];
	assign e_d2 = ent[OD2 +: DW];
	assign e_fq = ent[OFQ +: FW];
	assign e_hl = ent[OHL +: HW];
	assign e_gn = ent[OGN +: GW];

	// envelope
	logic              act_i, idle, hold_nz, rel_end;
	logic signed [GW:0] g_dec;
	logic [GW-1:0]     g_new;
	logic [HW-1:0]     h_new;

	always_comb begin
		act_i   = act_q[idx];
		hold_nz = e_hl != '0;
		idle    = !act_i && (e_gn == '0);
		g_dec   = $signed({1'b0, e_gn}) - $signed({2'b0, cfg.release_step});
		rel_end = !idle && !hold_nz && !act_i && (g_dec <= 0);
		if (hold_nz) begin
			g_new = nfb_pkg::GAIN_ONE;
			h_new = e_hl - HW'(1);
		end else begin
			g_new = act_i ? nfb_pkg::GAIN_ONE : g_dec[GW-1:0];
			h_new = e_hl;
		end
	end
	assign st.skip = idle || rel_end;

	// product rescaling and saturation
	logic signed [S+C-1:0] pb0_sh, pb1_sh;
	logic signed [WW-1:0]  pb0_r, pb1_r, y_sum, fa1_r, fa2_r, d1_sum, d2_sum;
	logic signed [31:0]    y_n, ys;
	logic signed [C+31:0]  fa1_sh, fa2_sh;
	logic signed [DW-1:0]  d1_n, d2_n;
	logic signed [S+3:0]   x_sum;
	logic signed [S-1:0]   x_n;

	always_comb begin
		pb0_sh = pb0_q >>> PSH_P;
		pb1_sh = pb1_q >>> PSH_P;
		pb0_r  = WW'(pb0_sh) <<< PSH_N;
		pb1_r  = WW'(pb1_sh) <<< PSH_N;
		y_sum  = pb0_r + WW'(e_d1);
		if (y_sum > YMAX) begin
			y_n = 32'(YMAX);
		end else if (y_sum < YMIN) begin
			y_n = 32'(YMIN);
		end else begin
			y_n = 32'(y_sum);
		end
		ys     = y_q >>> (32 - S);
		fa1_sh = fa1_q >>> (C - 2);
		fa2_sh = fa2_q >>> (C - 2);
		fa1_r  = WW'(fa1_sh);
		fa2_r  = WW'(fa2_sh);
		d1_sum = pb1_r - fa1_r + WW'(e_d2);
		d2_sum = pb0_r - fa2_r;
		if (d1_sum > ZMAX) begin
			d1_n = DW'(ZMAX);
		end else if (d1_sum < ZMIN) begin
			d1_n = DW'(ZMIN);
		end else begin
			d1_n = DW'(d1_sum);
		end
		if (d2_sum > ZMAX) begin
			d2_n = DW'(ZMAX);
		end else if (d2_sum < ZMIN) begin
			d2_n = DW'(ZMIN);
		end else begin
			d2_n = DW'(d2_sum);
		end
		x_sum = (S+4)'(x_q) + (S+4)'(gm_q >>> 16);
		if (x_sum > XMAX) begin
			x_n = S'(XMAX);
		end else if (x_sum < XMIN) begin
			x_n = S'(XMIN);
		end else begin
			x_n = S'(x_sum);
		end
	end

	// tone update
	logic          f_valid, act_s, reload, clr, act_new;
	logic [FW-1:0] delta;
	logic [EW-1:0] tone_ent;

	always_comb begin
		act_s    = act_q[slot_a];
		f_valid  = (freq_q != '0) && (freq_q < cfg.nyquist_limit);
		delta    = (freq_q > e_fq) ? freq_q - e_fq : e_fq - freq_q;
		reload   = (delta > cfg.small_delta) || !act_s;
		clr      = (delta > cfg.large_delta) || !act_s;
		tone_ent = ent;
		act_new  = act_s;
		if (f_valid) begin
			if (reload) begin
				if (clr) begin
					tone_ent[OD1 +: DW] = '0;
					tone_ent[OD2 +: DW] = '0;
				end
				tone_ent[C-1:0]     = b0_q;
				tone_ent[2*C-1:C]   = b1_q;
				tone_ent[3*C-1:2*C] = a2_q;
				tone_ent[OFQ +: FW] = freq_q;
			end
			tone_ent[OGN +: GW] = nfb_pkg::GAIN_ONE;
			tone_ent[OHL +: HW] = cfg.hold_length;
			act_new             = 1'b1;
		end else if (e_hl == '0) begin
			tone_ent[OD1 +: DW] = '0;
			tone_ent[OD2 +: DW] = '0;
			tone_ent[OFQ +: FW] = '0;
			act_new             = 1'b0;
		end
	end

	// write back selection
	always_comb begin
		we      = cmd.tone_wr || cmd.wb_en || (cmd.env && rel_end);
		wr_data = ent;
		if (cmd.tone_wr) begin
			wr_data = tone_ent;
		end else if (cmd.wb_en) begin
			wr_data[OD1 +: DW] = d1n_q;
			wr_data[OD2 +: DW] = d2n_q;
			wr_data[OHL +: HW] = hn_q;
			wr_data[OGN +: GW] = gn_q;
		end else begin
			wr_data[OD1 +: DW] = '0;
			wr_data[OD2 +: DW] = '0;
			wr_data[OFQ +: FW] = '0;
			wr_data[OGN +: GW] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= '0;
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cmd.rd_en) begin
				vld_rd_q <= vld_q[raddr];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (cmd.tone_wr) begin
				act_q[slot_a] <= act_new;
				if (act_new && !act_s) begin
					cnt_q <= cnt_q + nfb_pkg::COUNT_W'(1);
				end else if (!act_new && act_s) begin
					cnt_q <= cnt_q - nfb_pkg::COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			slot_q <= in_slot;
			freq_q <= in_freq;
			b0_q   <= in_b0;
			b1_q   <= in_b1;
			a2_q   <= in_a2;
			x_q    <= in_sample;
		end else if (cmd.wb_en) begin
			x_q <= x_n;
		end
		if (cmd.env) begin
			pb0_q <= e_b0 * x_q;
			pb1_q <= e_b1 * x_q;
			gn_q  <= g_new;
			hn_q  <= h_new;
		end
		if (cmd.y_en) begin
			y_q <= y_n;
		end
		if (cmd.fb_en) begin
			fa1_q  <= e_b1 * y_q;
			fa2_q  <= e_a2 * y_q;
			diff_q <= (S+1)'(ys) - (S+1)'(x_q);
		end
		if (cmd.gm_en) begin
			d1n_q <= d1_n;
			d2n_q <= d2_n;
			gm_q  <= diff_q * $signed({1'b0, gn_q});
		end
		if (cmd.out_load) begin
			out_sample <= op_q ? '0 : x_q;
			out_count  <= cnt_q;
		end
	end
endmodule

[rtl/notch_filter_bank_with_release.sv]
// top level of the notch filter bank with hold and linear release
//
// input stream (s_*): one transfer is either an audio sample (s_tuser low) or a
// tone update for one notch slot (s_tuser high), carrying the slot, the tone
// frequency and three coefficients worked out by the host
// output stream (m_*): exactly one transfer per input transfer, in order, with
// the filtered sample (zero for tone updates) and the active notch count
// configuration: single-cycle writes through cfg_we / cfg_index / cfg_data,
// only while the block is idle; unknown indices are ignored
// sequencing: a tone update reads its slot, writes it and then loads its result;
// one whose slot is out of range is dropped and goes straight to the output
// register; for a sample the shared biquad datapath works through the notches
// one after another, five steps for each live notch and one for each idle one
// one item is in flight at a time; a new item is taken once the previous
// result sits in the output register, so a stalled receiver holds back at
// most one result before s_tready drops
// reset: all notches idle at unity passthrough, registers at their defaults;
// the slot store needs no clearing pass, per-slot valid bits cover it
module notch_filter_bank_with_release #(
	parameter int NOTCH_COUNT = nfb_pkg::NOTCH_COUNT_DEF,
	parameter int SAMPLE_BITS = nfb_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = nfb_pkg::COEF_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// tone update / sample input
	input  logic s_tvalid,
	output logic s_tready,
	// from bit 0: sample_in, slot, tone_freq, coef_b0, coef_b1, coef_a2, zero pad
	input  logic [((SAMPLE_BITS + 24 + 3 * COEF_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// from bit 0: operation
	input  logic s_tuser,
	// results
	output logic m_tvalid,
	input  logic m_tready,
	// from bit 0: sample_out, active_count, zero pad
	output logic [((SAMPLE_BITS + 5 + 7) / 8) * 8 - 1:0] m_tdata,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [nfb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nfb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int AW    = (NOTCH_COUNT > 1) ? $clog2(NOTCH_COUNT) : 1;
	localparam int S     = SAMPLE_BITS;
	localparam int C     = COEF_BITS;
	localparam int OUT_W = ((S + 5 + 7) / 8) * 8;
	localparam int O_SL  = S;
	localparam int O_FQ  = O_SL + nfb_pkg::SLOT_W;
	localparam int O_B0  = O_FQ + nfb_pkg::FREQ_W;
	localparam int O_B1  = O_B0 + C;
	localparam int O_A2  = O_B1 + C;

	nfb_pkg::cfg_t    cfg_q;
	nfb_pkg::cmd_t    cmd;
	nfb_pkg::status_t st;
	logic [AW-1:0]    idx, rd_idx;
	logic signed [S-1:0] out_sample;
	logic [nfb_pkg::COUNT_W-1:0] out_count;

	// register file; the user must write it only between items, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_length   <= nfb_pkg::HOLD_LENGTH_RST;
			cfg_q.release_step  <= nfb_pkg::RELEASE_STEP_RST;
			cfg_q.small_delta   <= nfb_pkg::SMALL_DELTA_RST;
			cfg_q.large_delta   <= nfb_pkg::LARGE_DELTA_RST;
			cfg_q.nyquist_limit <= nfb_pkg::NYQUIST_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nfb_pkg::REG_HOLD_LENGTH:   cfg_q.hold_length   <= cfg_data[15:0];
				nfb_pkg::REG_RELEASE_STEP:  cfg_q.release_step  <= cfg_data[15:0];
				nfb_pkg::REG_SMALL_DELTA:   cfg_q.small_delta   <= cfg_data;
				nfb_pkg::REG_LARGE_DELTA:   cfg_q.large_delta   <= cfg_data;
				nfb_pkg::REG_NYQUIST_LIMIT: cfg_q.nyquist_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nfb_ctrl #(.NOTCH_COUNT(NOTCH_COUNT)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd),
		.idx      (idx),
		.rd_idx   (rd_idx)
	);

	nfb_dp #(
		.NOTCH_COUNT (NOTCH_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_op      (s_tuser),
		.in_sample  (s_tdata[S-1:0]),
		.in_slot    (s_tdata[O_SL +: nfb_pkg::SLOT_W]),
		.in_freq    (s_tdata[O_FQ +: nfb_pkg::FREQ_W]),
		.in_b0      (s_tdata[O_B0 +: C]),
		.in_b1      (s_tdata[O_B1 +: C]),
		.in_a2      (s_tdata[O_A2 +: C]),
		.cmd        (cmd),
		.idx        (idx),
		.rd_idx     (rd_idx),
		.st         (st),
		.out_sample (out_sample),
		.out_count  (out_count)
	);

	assign m_tdata = OUT_W'({out_count, out_sample});

	// one item at a time: the sequencer must leave idle after taking a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// a result is only loaded when the output register is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	// the active count never moves outside a tone update
	a_count_tone_only: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.tone_wr) |-> $stable(u_dp.cnt_q))
		else $error("active count changed without a tone update");
endmodule
